// ----- sv/rpt_pkg.sv -----
package rpt_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int ROT_WIDTH       = 20;
    localparam int COLOR_WIDTH     = 24;
    localparam int CFG_INDEX_WIDTH = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_X   = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Y   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROT_Z   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Y = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Z = 3'd5;

    // Q.30 angle constants
    localparam logic signed [32:0] CORDIC_START = 33'sh026DD3B6A;
    localparam logic signed [35:0] PI_Q30       = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30  = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30   = 36'sd6746518852;
    localparam logic signed [34:0] ONE_Q30      = 35'sd1073741824;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] point_z;
        logic [COLOR_WIDTH-1:0]        color_in;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic [COLOR_WIDTH-1:0]        color_out;
        logic                          overflow;
    } point_out_t;

    // where one matrix entry sits and how its cross-product term enters
    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] other;
        logic       diag;
        logic       pos;
    } entry_info_t;

    function automatic entry_info_t entry_info(input logic [3:0] ent);
        entry_info_t e;
        e = '0;
        unique case (ent)
            4'd0: e = '{row: 2'd0, col: 2'd0, other: 2'd0, diag: 1'b1, pos: 1'b0};
            4'd1: e = '{row: 2'd0, col: 2'd1, other: 2'd2, diag: 1'b0, pos: 1'b0};
            4'd2: e = '{row: 2'd0, col: 2'd2, other: 2'd1, diag: 1'b0, pos: 1'b1};
            4'd3: e = '{row: 2'd1, col: 2'd0, other: 2'd2, diag: 1'b0, pos: 1'b1};
            4'd4: e = '{row: 2'd1, col: 2'd1, other: 2'd0, diag: 1'b1, pos: 1'b0};
            4'd5: e = '{row: 2'd1, col: 2'd2, other: 2'd0, diag: 1'b0, pos: 1'b0};
            4'd6: e = '{row: 2'd2, col: 2'd0, other: 2'd1, diag: 1'b0, pos: 1'b0};
            4'd7: e = '{row: 2'd2, col: 2'd1, other: 2'd0, diag: 1'b0, pos: 1'b1};
            4'd8: e = '{row: 2'd2, col: 2'd2, other: 2'd0, diag: 1'b1, pos: 1'b0};
            default: e = '0;
        endcase
        return e;
    endfunction

    // truncated arctangent table, Q.30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        v = '0;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/rpt_matrix_gen.sv -----
module rpt_matrix_gen
    import rpt_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18,
    parameter int MW           = FRAC_BITS + 2
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [2:0][ROT_WIDTH-1:0]        rot,
    output logic                             busy,
    output logic [8:0][MW-1:0]               matrix
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SQRT   = 7'b0000010,
        ST_DIV    = 7'b0000100,
        ST_REDUCE = 7'b0001000,
        ST_CORDIC = 7'b0010000,
        ST_MAT_A  = 7'b0100000,
        ST_MAT_B  = 7'b1000000
    } gen_state_t;

    localparam logic [MW-1:0] ONE_ENT = MW'(1) << FRAC_BITS;
    localparam logic signed [40:0] ENT_MAX = (41'sd1 <<< (FRAC_BITS + 1)) - 41'sd1;
    localparam logic signed [40:0] ENT_MIN = -(41'sd1 <<< (FRAC_BITS + 1));
    localparam logic signed [40:0] RND     = 41'sd1 <<< (29 - FRAC_BITS);

    gen_state_t state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  ent_reg, ent_next;
    logic [8:0][MW-1:0] mat_reg, mat_next;

    logic [63:0] rad_reg, rad_next;
    logic [33:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [19:0] mag_reg [3];
    logic [19:0] mag_next [3];
    logic [2:0]  sign_reg, sign_next;
    logic [31:0] drem_reg [3];
    logic [31:0] drem_next [3];
    logic [30:0] q_reg [3];
    logic [30:0] q_next [3];
    logic signed [35:0] ang_reg, ang_next;
    logic        neg_reg, neg_next;
    logic signed [32:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [33:0] kk_reg, kk_next;
    logic signed [34:0] sk_reg, sk_next;

    logic signed [39:0] sq [3];
    logic [39:0] sum_sq;
    logic [35:0] rem_t, trial;
    logic        root_ge;
    logic [32:0] dt [3];
    logic        dge [3];
    logic signed [31:0] k [3];
    logic signed [32:0] c_val, dx, dy, at;
    logic signed [34:0] omc;
    logic signed [63:0] kprod;
    logic signed [64:0] sprod;
    logic signed [68:0] mprod;
    logic signed [40:0] mv, addend, vsum, vq;
    entry_info_t info;

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            sq[n] = $signed(rot[n]) * $signed(rot[n]);
            k[n]  = sign_reg[n] ? -$signed({1'b0, q_reg[n]}) : $signed({1'b0, q_reg[n]});
            dt[n]  = {drem_reg[n], mag_reg[n][19]};
            dge[n] = dt[n] >= {1'b0, root_reg};
        end
        sum_sq  = sq[0][39:0] + sq[1][39:0] + sq[2][39:0];
        rem_t   = {rem_reg, rad_reg[63:62]};
        trial   = {2'b00, root_reg, 2'b01};
        root_ge = rem_t >= trial;
        dx      = y_reg >>> cnt_reg[4:0];
        dy      = x_reg >>> cnt_reg[4:0];
        at      = $signed({1'b0, atan_q30(cnt_reg[4:0])});
        c_val   = neg_reg ? -x_reg : x_reg;
        omc     = ONE_Q30 - 35'(c_val);
        info    = entry_info(ent_reg);
        kprod   = k[info.row] * k[info.col];
        sprod   = y_reg * k[info.other];
        mprod   = omc * kk_reg;
        mv      = 41'($signed(mprod[68:30]));
        if (info.diag)
            addend = 41'(c_val);
        else if (info.pos)
            addend = 41'(sk_reg);
        else
            addend = -41'(sk_reg);
        vsum    = mv + addend + RND;
        vq      = vsum >>> (30 - FRAC_BITS);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ent_next   = ent_reg;
        mat_next   = mat_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        sign_next  = sign_reg;
        ang_next   = ang_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        kk_next    = kk_reg;
        sk_next    = sk_reg;
        for (int n = 0; n < 3; n++)
        begin
            mag_next[n]  = mag_reg[n];
            drem_next[n] = drem_reg[n];
            q_next[n]    = q_reg[n];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (sum_sq == '0)
                    begin
                        for (int e = 0; e < 9; e++)
                            mat_next[e] = (e % 4 == 0) ? ONE_ENT : '0;
                    end
                    else
                    begin
                        rad_next   = {sum_sq, 24'b0};
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = 6'd31;
                        state_next = ST_SQRT;
                        for (int n = 0; n < 3; n++)
                        begin
                            sign_next[n] = rot[n][ROT_WIDTH-1];
                            mag_next[n]  = rot[n][ROT_WIDTH-1] ? -rot[n] : rot[n];
                        end
                    end
                end
            end
            ST_SQRT:
            begin
                rem_next  = root_ge ? 34'(rem_t - trial) : rem_t[33:0];
                root_next = {root_reg[30:0], root_ge};
                rad_next  = {rad_reg[61:0], 2'b00};
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = 6'd61;
                    state_next = ST_DIV;
                    for (int n = 0; n < 3; n++)
                    begin
                        drem_next[n] = '0;
                        q_next[n]    = '0;
                    end
                end
            end
            ST_DIV:
            begin
                for (int n = 0; n < 3; n++)
                begin
                    drem_next[n] = dge[n] ? 32'(dt[n] - {1'b0, root_reg}) : dt[n][31:0];
                    q_next[n]    = {q_reg[n][29:0], dge[n]};
                    mag_next[n]  = {mag_reg[n][18:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    ang_next   = $signed({2'b00, root_reg, 2'b00});
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (ang_reg > PI_Q30)
                    ang_next = ang_reg - TWO_PI_Q30;
                else
                begin
                    neg_next = 1'b0;
                    z_next   = 33'(ang_reg);
                    if (ang_reg > HALF_PI_Q30)
                    begin
                        z_next   = 33'(PI_Q30 - ang_reg);
                        neg_next = 1'b1;
                    end
                    else if (ang_reg < -HALF_PI_Q30)
                    begin
                        z_next   = 33'(-PI_Q30 - ang_reg);
                        neg_next = 1'b1;
                    end
                    x_next     = CORDIC_START;
                    y_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1))
                begin
                    ent_next   = '0;
                    state_next = ST_MAT_A;
                end
            end
            ST_MAT_A:
            begin
                kk_next    = kprod[63:30];
                sk_next    = sprod[64:30];
                state_next = ST_MAT_B;
            end
            ST_MAT_B:
            begin
                if (vq > ENT_MAX)
                    mat_next[ent_reg] = ENT_MAX[MW-1:0];
                else if (vq < ENT_MIN)
                    mat_next[ent_reg] = ENT_MIN[MW-1:0];
                else
                    mat_next[ent_reg] = vq[MW-1:0];
                ent_next   = ent_reg + 4'd1;
                state_next = (ent_reg == 4'd8) ? ST_IDLE : ST_MAT_A;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ent_reg   <= '0;
            for (int e = 0; e < 9; e++)
                mat_reg[e] <= (e % 4 == 0) ? ONE_ENT : '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ent_reg   <= ent_next;
            mat_reg   <= mat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        sign_reg <= sign_next;
        ang_reg  <= ang_next;
        neg_reg  <= neg_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        kk_reg   <= kk_next;
        sk_reg   <= sk_next;
        for (int n = 0; n < 3; n++)
        begin
            mag_reg[n]  <= mag_next[n];
            drem_reg[n] <= drem_next[n];
            q_reg[n]    <= q_next[n];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign matrix = mat_reg;

endmodule

// ----- sv/rpt_point_pipe.sv -----
module rpt_point_pipe
    import rpt_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MW        = FRAC_BITS + 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hold,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  point_in_t                     in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output point_out_t                    out_data,
    input  logic [8:0][MW-1:0]            matrix,
    input  logic [2:0][COORD_WIDTH-1:0]   shift
);

    localparam int PW = MW + COORD_WIDTH;
    localparam int SW = PW + 2;
    localparam int AW = SW - FRAC_BITS;
    localparam int TW = AW + 1;
    localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [TW-1:0] C_MAX = TW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [TW-1:0] C_MIN = -C_MAX - TW'(1);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic signed [PW-1:0] prod_reg [9];
    logic signed [PW-1:0] prod_next [9];
    logic signed [AW-1:0] acc_reg [3];
    logic signed [AW-1:0] acc_next [3];
    logic [COLOR_WIDTH-1:0] color1_reg, color2_reg;
    point_out_t out_reg, out_next;

    logic signed [COORD_WIDTH-1:0] pt [3];
    logic signed [SW-1:0] sum [3];
    logic signed [TW-1:0] t [3];
    logic signed [COORD_WIDTH-1:0] sat [3];
    logic [2:0] ovf;

    // advance a stage when its successor has room
    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1 && !hold;

    always_comb
    begin
        pt[0] = in_data.point_x;
        pt[1] = in_data.point_y;
        pt[2] = in_data.point_z;
        for (int e = 0; e < 9; e++)
            prod_next[e] = $signed(matrix[e]) * pt[e % 3];
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = SW'(prod_reg[3*i]) + SW'(prod_reg[3*i+1]) + SW'(prod_reg[3*i+2])
                     + RND_HALF;
            acc_next[i] = AW'(sum[i] >>> FRAC_BITS);
        end
        for (int i = 0; i < 3; i++)
        begin
            t[i] = TW'(acc_reg[i]) + TW'($signed(shift[i]));
            ovf[i] = 1'b1;
            if (t[i] > C_MAX)
                sat[i] = C_MAX[COORD_WIDTH-1:0];
            else if (t[i] < C_MIN)
                sat[i] = C_MIN[COORD_WIDTH-1:0];
            else
            begin
                sat[i] = t[i][COORD_WIDTH-1:0];
                ovf[i] = 1'b0;
            end
        end
        out_next.out_x     = sat[0];
        out_next.out_y     = sat[1];
        out_next.out_z     = sat[2];
        out_next.color_out = color2_reg;
        out_next.overflow  = |ovf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid && in_ready;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            prod_reg   <= prod_next;
            color1_reg <= in_data.color_in;
        end
        if (en2)
        begin
            acc_reg    <= acc_next;
            color2_reg <= color1_reg;
        end
        if (en3)
            out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

// ----- sv/rigid_point_transform.sv -----
// Channel     | Handshake              | Payload
// ------------+------------------------+-------------------------------------
// cfg         | cfg_we (no wait)       | cfg_index, cfg_data
// in          | in_valid / in_ready    | in_data  (point_x/y/z, color_in)
// out         | out_valid / out_ready  | out_data (out_x/y/z, color_out, overflow)
//
// Points pass three register stages (products, sum and round, shift and saturate) at one
// request per cycle unless held or back-pressured; a stalled output holds its result
// while the earlier stages keep filling their empty slots.
// A rotation write marks the matrix stale and holds new points through the rebuild (start,
// square root, divide, angle reduction, CORDIC, then the nine entries via ST_MAT_A and
// ST_MAT_B). A zero rotation vector loads the identity directly from idle, with no rebuild.
// Reset clears the configuration and control registers, loads the identity matrix and empties the pipe.
module rigid_point_transform
    import rpt_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 18
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]      cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  point_in_t                   in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output point_out_t                  out_data
);

    localparam int MW = FRAC_BITS + 2;

    logic [2:0][ROT_WIDTH-1:0]   rot_reg, rot_next;
    logic [2:0][COORD_WIDTH-1:0] shift_reg, shift_next;
    logic                        pending_reg, pending_next;
    logic                        rot_wr;
    logic                        gen_start;
    logic                        gen_busy;
    logic [8:0][MW-1:0]          matrix;

    // hold the register file; any rotation write marks the matrix stale
    always_comb
    begin
        rot_next   = rot_reg;
        shift_next = shift_reg;
        rot_wr     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_X:
                begin
                    rot_next[0] = cfg_data[ROT_WIDTH-1:0];
                    rot_wr      = 1'b1;
                end
                REG_ROT_Y:
                begin
                    rot_next[1] = cfg_data[ROT_WIDTH-1:0];
                    rot_wr      = 1'b1;
                end
                REG_ROT_Z:
                begin
                    rot_next[2] = cfg_data[ROT_WIDTH-1:0];
                    rot_wr      = 1'b1;
                end
                REG_SHIFT_X: shift_next[0] = cfg_data;
                REG_SHIFT_Y: shift_next[1] = cfg_data;
                REG_SHIFT_Z: shift_next[2] = cfg_data;
                default: ;
            endcase
        end
    end

    // start a rebuild when stale and idle; a write during a rebuild forces another
    assign gen_start = pending_reg && !gen_busy;

    always_comb
    begin
        priority if (rot_wr)
            pending_next = 1'b1;
        else if (gen_start)
            pending_next = 1'b0;
        else
            pending_next = pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg     <= '0;
            shift_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            rot_reg     <= rot_next;
            shift_reg   <= shift_next;
            pending_reg <= pending_next;
        end
    end

    rpt_matrix_gen #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS),
        .MW           (MW)
    ) u_matrix_gen (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gen_start),
        .rot    (rot_reg),
        .busy   (gen_busy),
        .matrix (matrix)
    );

    rpt_point_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .MW        (MW)
    ) u_point_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (pending_reg || gen_busy),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .matrix    (matrix),
        .shift     (shift_reg)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_stale: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !(gen_busy || pending_reg))
        else $error("point accepted while matrix is stale");

    a_rot_marks_stale: assert property (@(posedge clk) disable iff (!rst_n)
        rot_wr |=> pending_reg)
        else $error("rotation write did not mark matrix stale");

    a_stale_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg && !gen_busy && !rot_wr) |=> !pending_reg)
        else $error("stale matrix not rebuilt");
`endif

endmodule
